>>> sv/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg: shared definitions for the binary heap priority queue
// Field widths, stream packing layout, command and status codes.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    // Input transaction fields
    localparam int CMD_W        = 2;
    localparam int IN_KEY_W     = 32;
    localparam int IN_PAYLOAD_W = 16;

    // Result transaction fields
    localparam int TOP_KEY_W     = 32;
    localparam int TOP_PAYLOAD_W = 16;
    localparam int COUNT_W       = 7;
    localparam int STATUS_W      = 2;

    // Stream bus widths
    localparam int S_TDATA_W = 48;   // key, payload
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 64;   // top_key, top_payload, entry_count, status, pad
    localparam int M_TUSER_W = 1;    // top_valid

    // Result tdata bit positions
    localparam int M_PAYLOAD_LSB = TOP_KEY_W;
    localparam int M_COUNT_LSB   = M_PAYLOAD_LSB + TOP_PAYLOAD_W;
    localparam int M_STATUS_LSB  = M_COUNT_LSB + COUNT_W;
    localparam int M_PAD_W       = M_TDATA_W - M_STATUS_LSB - STATUS_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

>>> sv/binary_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core: binary heap priority queue
// Array-based heap of key/payload entries with push, pop and peek commands.
// ----------------------------------------------------------------------------
// Each input transaction carries a command (push, pop or peek) and, for a push,
// a key and a payload; each produces exactly one result transaction with the
// top entry after the operation, a valid flag, the entry count and a status.
// The block works on one transaction at a time and drops s_axis_tready while
// busy; a finished result sits in an output register, so the next command is
// taken while that result still waits for m_axis_tready. Timing is set by a
// single shared key comparator and the registered reads of the entry memory.
// A peek, a full push, an empty pop and a pop that empties the heap only read
// the root. A push climbs by a parent read and a compare per level until a
// compare stops it or it reaches the root, then settles its entry. A pop takes
// the last entry to the root and sinks it by a read of both children and two
// compares per level, then settles it. i_cfg_we writes max_first (0: smallest
// key first, 1: largest key first); write it only while idle.
// Equal keys never pass each other, and on a sift down the right child wins
// only when strictly better than the left.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core #(
    parameter int CAPACITY      = 64,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: max_first
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    // Command stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bhpq_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // key[31:0], payload[47:32]
    input  logic [bhpq_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // command[1:0]
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // top_key[31:0], top_payload[47:32], entry_count[54:48], status[56:55], zero[63:57]
    output logic [bhpq_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic [bhpq_pkg::M_TUSER_W-1:0]    m_axis_tuser   // top_valid[0]
);

    import bhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);        // slot address
    localparam int CW = $clog2(CAPACITY + 1);    // entry count
    localparam int XW = AW + 2;                  // child index, holds 2*CAPACITY
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_RD,
        ST_POP_LD,
        ST_DN_RD,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_WR_CUR,
        ST_TOP_RD,
        ST_TOP_OUT
    } t_state;

    t_state                r_state;
    logic                  r_max_first;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx;        // slot the moving entry currently owns
    logic [EW-1:0]         r_cur;        // moving entry
    logic [EW-1:0]         r_best;       // better of moving entry and left child
    logic [AW-1:0]         r_best_idx;
    logic                  r_best_child;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_m_valid;
    logic [M_TDATA_W-1:0]  r_m_data;
    logic [M_TUSER_W-1:0]  r_m_user;

    // Memory and comparator hookup
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr_a;
    logic [AW-1:0]         mem_raddr_b;
    logic [EW-1:0]         mem_rdata_a;
    logic [EW-1:0]         mem_rdata_b;
    logic [KEY_WIDTH-1:0]  cmp_key_a;
    logic [KEY_WIDTH-1:0]  cmp_key_b;
    logic                  cmp_before;

    // Tree navigation
    logic [AW-1:0]         parent_idx;
    logic [XW-1:0]         left_x;
    logic [XW-1:0]         right_x;
    logic [XW-1:0]         count_x;
    logic                  left_ok;
    logic                  right_ok;
    logic                  right_wins;

    // Input fields
    logic [CMD_W-1:0]      in_cmd;
    logic [EW-1:0]         in_entry;

    // Result fields
    logic                  top_valid;
    logic [TOP_KEY_W-1:0]     top_key;
    logic [TOP_PAYLOAD_W-1:0] top_payload;

    assign in_cmd   = s_axis_tuser;
    assign in_entry = {PAYLOAD_WIDTH'(s_axis_tdata[S_TDATA_W-1:IN_KEY_W]),
                       KEY_WIDTH'(s_axis_tdata[IN_KEY_W-1:0])};

    assign parent_idx = (r_idx - AW'(1)) >> 1;
    assign left_x     = XW'({r_idx, 1'b1});
    assign right_x    = left_x + XW'(1);
    assign count_x    = XW'(r_count);
    assign left_ok    = left_x < count_x;
    assign right_ok   = right_x < count_x;
    assign right_wins = right_ok && cmp_before;

    assign s_axis_tready = (r_state == ST_IDLE);

    // ------------------------------------------------------------------------
    // Entry store and the shared comparator
    // ------------------------------------------------------------------------
    bhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (EW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    bhpq_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_key_a     (cmp_key_a),
        .i_key_b     (cmp_key_b),
        .i_max_first (r_max_first),
        .o_a_before  (cmp_before)
    );

    // ------------------------------------------------------------------------
    // Memory ports and comparator operands, selected by sequencer state
    // ------------------------------------------------------------------------
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_cur;
        mem_re      = 1'b0;
        mem_raddr_a = '0;
        mem_raddr_b = right_x[AW-1:0];
        cmp_key_a   = r_cur[KEY_WIDTH-1:0];
        cmp_key_b   = mem_rdata_a[KEY_WIDTH-1:0];
        unique case (r_state)
            ST_UP_RD: begin
                // Fetch the parent of the climbing entry
                mem_re      = 1'b1;
                mem_raddr_a = parent_idx;
            end
            ST_UP_CMP: begin
                // Moving entry vs parent; on a win the parent drops into our slot
                mem_we    = cmp_before;
                mem_wdata = mem_rdata_a;
            end
            ST_POP_RD: begin
                // Fetch the last entry, which replaces the root
                mem_re      = 1'b1;
                mem_raddr_a = r_count[AW-1:0];
            end
            ST_DN_RD: begin
                // Fetch both children at once
                mem_re      = left_ok;
                mem_raddr_a = left_x[AW-1:0];
            end
            ST_DN_LEFT: begin
                cmp_key_a = mem_rdata_a[KEY_WIDTH-1:0];
                cmp_key_b = r_cur[KEY_WIDTH-1:0];
            end
            ST_DN_RIGHT: begin
                // Right child vs the better of left child and moving entry;
                // the winning child moves up into our slot
                cmp_key_a = mem_rdata_b[KEY_WIDTH-1:0];
                cmp_key_b = r_best[KEY_WIDTH-1:0];
                mem_we    = right_wins || r_best_child;
                mem_wdata = right_wins ? mem_rdata_b : r_best;
            end
            ST_WR_CUR: begin
                // Settle the moving entry in its final slot
                mem_we = 1'b1;
            end
            ST_TOP_RD: begin
                mem_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Result fields; an empty heap shows zeros
    assign top_valid   = (r_count != '0);
    assign top_key     = top_valid ? TOP_KEY_W'(mem_rdata_a[KEY_WIDTH-1:0]) : '0;
    assign top_payload = top_valid ? TOP_PAYLOAD_W'(mem_rdata_a[EW-1:KEY_WIDTH]) : '0;

    // ------------------------------------------------------------------------
    // Sequencer, configuration and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_first <= 1'b0;
            r_count     <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_first <= i_cfg_wdata;
            end
            // Drop the result once the consumer takes it; in ST_TOP_OUT the
            // next result takes its place instead
            if (m_axis_tready && r_state != ST_TOP_OUT) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (in_cmd == CMD_PUSH) begin
                            if (r_count == CW'(CAPACITY)) begin
                                r_status <= STAT_FULL;
                                r_state  <= ST_TOP_RD;
                            end else begin
                                r_status <= STAT_OK;
                                r_cur    <= in_entry;
                                r_idx    <= r_count[AW-1:0];
                                r_count  <= r_count + CW'(1);
                                r_state  <= (r_count == '0) ? ST_WR_CUR : ST_UP_RD;
                            end
                        end else if (in_cmd == CMD_POP) begin
                            if (r_count == '0) begin
                                r_status <= STAT_EMPTY;
                                r_state  <= ST_TOP_RD;
                            end else begin
                                r_status <= STAT_OK;
                                r_count  <= r_count - CW'(1);
                                r_state  <= (r_count != CW'(1)) ? ST_POP_RD : ST_TOP_RD;
                            end
                        end else begin
                            // Peek and the unused code only report the top
                            r_status <= STAT_OK;
                            r_state  <= ST_TOP_RD;
                        end
                    end
                end
                ST_UP_RD: begin
                    r_state <= ST_UP_CMP;
                end
                ST_UP_CMP: begin
                    if (cmp_before) begin
                        r_idx   <= parent_idx;
                        r_state <= (parent_idx == '0) ? ST_WR_CUR : ST_UP_RD;
                    end else begin
                        r_state <= ST_WR_CUR;
                    end
                end
                ST_POP_RD: begin
                    r_state <= ST_POP_LD;
                end
                ST_POP_LD: begin
                    r_cur   <= mem_rdata_a;
                    r_idx   <= '0;
                    r_state <= ST_DN_RD;
                end
                ST_DN_RD: begin
                    r_state <= left_ok ? ST_DN_LEFT : ST_WR_CUR;
                end
                ST_DN_LEFT: begin
                    if (cmp_before) begin
                        r_best       <= mem_rdata_a;
                        r_best_idx   <= left_x[AW-1:0];
                        r_best_child <= 1'b1;
                    end else begin
                        r_best       <= r_cur;
                        r_best_child <= 1'b0;
                    end
                    r_state <= ST_DN_RIGHT;
                end
                ST_DN_RIGHT: begin
                    if (right_wins) begin
                        r_idx   <= right_x[AW-1:0];
                        r_state <= ST_DN_RD;
                    end else if (r_best_child) begin
                        r_idx   <= r_best_idx;
                        r_state <= ST_DN_RD;
                    end else begin
                        r_state <= ST_WR_CUR;
                    end
                end
                ST_WR_CUR: begin
                    r_state <= ST_TOP_RD;
                end
                ST_TOP_RD: begin
                    r_state <= ST_TOP_OUT;
                end
                ST_TOP_OUT: begin
                    // Hold until the output register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {{M_PAD_W{1'b0}}, r_status, COUNT_W'(r_count),
                                      top_payload, top_key};
                        r_m_user  <= top_valid;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

>>> sv/bhpq_cmp.sv
// ----------------------------------------------------------------------------
// bhpq_cmp: shared key comparator
// Tells whether key a is served strictly before key b under the current order.
// ----------------------------------------------------------------------------
module bhpq_cmp #(
    parameter int KEY_WIDTH = 32
) (
    input  logic [KEY_WIDTH-1:0] i_key_a,
    input  logic [KEY_WIDTH-1:0] i_key_b,
    input  logic                 i_max_first,
    output logic                 o_a_before
);

    // Strict compare: equal keys never reorder
    assign o_a_before = i_max_first ? (i_key_a > i_key_b) : (i_key_a < i_key_b);

endmodule

>>> sv/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram: heap entry store
// One write port and two read ports sharing a read enable, registered reads.
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

>>> sv/bhpq_checker.sv
// ----------------------------------------------------------------------------
// bhpq_checker: port-level checks for the heap priority queue
// Watches the stream ports of the core; attached by bind.
// ----------------------------------------------------------------------------
module bhpq_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [bhpq_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic [bhpq_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

    import bhpq_pkg::*;

    logic [STATUS_W-1:0] out_status;
    logic [COUNT_W-1:0]  out_count;

    assign out_status = m_axis_tdata[M_STATUS_LSB +: STATUS_W];
    assign out_count  = m_axis_tdata[M_COUNT_LSB +: COUNT_W];

    // One command at a time: busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted while a previous one is in work");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // An empty heap reports no entries and a zero top entry
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (out_count == '0 && m_axis_tdata[M_COUNT_LSB-1:0] == '0))
        else $error("empty heap result carries data");

    // A refused pop means the heap was and stays empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_status == STAT_EMPTY) |-> !m_axis_tuser[0])
        else $error("pop refused with entries present");

endmodule

bind binary_heap_priority_queue_core bhpq_checker u_bhpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
